// ----- rtl/core/ffr_pkg.sv -----
`timescale 1ns / 1ps

package ffr_pkg;

  // Frame layout
  localparam int unsigned DATA_WORDS = 9;
  localparam int unsigned SLOT_W     = 4;
  localparam logic [SLOT_W-1:0] CHECK_SLOT = 4'd9;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_WORD = 2'd0;
  localparam logic [1:0] REG_WRAP_LOW  = 2'd1;
  localparam logic [1:0] REG_WRAP_HIGH = 2'd2;

  // Configuration reset values
  localparam logic [15:0] SYNC_WORD_RST = 16'd43981;
  localparam logic [15:0] WRAP_LOW_RST  = 16'd2700;
  localparam logic [15:0] WRAP_HIGH_RST = 16'd6300;

  // Payload word positions
  localparam int unsigned W_CMD_ONE  = 0;
  localparam int unsigned W_CMD_TWO  = 1;
  localparam int unsigned W_SPD_R    = 2;
  localparam int unsigned W_SPD_L    = 3;
  localparam int unsigned W_CNT_R    = 4;
  localparam int unsigned W_CNT_L    = 5;
  localparam int unsigned W_BATT     = 6;
  localparam int unsigned W_TEMP     = 7;
  localparam int unsigned W_LED      = 8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HIGH = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] wrap_low;
    logic [15:0] wrap_high;
  } cfg_t;

  // One parsed frame handed from front to back
  typedef struct packed {
    logic [DATA_WORDS-1:0][15:0] words;
    logic                        ok;
  } frame_rec_t;

  // Wheel wrap-turn step: signed threshold crossing
  function automatic logic [15:0] turn_step(input logic [15:0] turns,
                                            input logic [15:0] prev,
                                            input logic [15:0] now,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] res;
    res = turns;
    if (($signed(now) < $signed(lo)) && ($signed(prev) > $signed(hi))) begin
      res = turns + 16'd1;
    end else if (($signed(now) > $signed(hi)) && ($signed(prev) < $signed(lo))) begin
      res = turns - 16'd1;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/ffr_front.sv -----
`timescale 1ns / 1ps

module ffr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         sync_word,
  output logic                rec_push,
  output ffr_pkg::frame_rec_t rec
);
  import ffr_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  byte_pos, byte_pos_next;
  logic [7:0]  pending, pending_next;
  logic [15:0] xor_acc, xor_acc_next;
  logic [DATA_WORDS-1:0][15:0] frame_words;
  logic        word_we;
  logic [SLOT_W-1:0] slot;
  logic [15:0] word;

  assign word = {rx_byte, pending};
  assign slot = byte_pos[4:1];

  // Hunt for sync, collect payload words, then push the frame on its checksum word
  always_comb begin
    phase_next    = phase;
    byte_pos_next = byte_pos;
    pending_next  = pending;
    xor_acc_next  = xor_acc;
    word_we       = 1'b0;
    rec_push      = 1'b0;
    if (accept) begin
      case (phase)
        PH_HIGH: begin
          if (rx_byte == sync_word[15:8]) begin
            xor_acc_next  = {rx_byte, pending};
            byte_pos_next = 5'd0;
            phase_next    = PH_BODY;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (!byte_pos[0]) begin
            pending_next  = rx_byte;
            byte_pos_next = byte_pos + 5'd1;
          end else if (slot != CHECK_SLOT) begin
            word_we       = 1'b1;
            xor_acc_next  = xor_acc ^ word;
            byte_pos_next = byte_pos + 5'd1;
          end else begin
            rec_push      = 1'b1;
            phase_next    = PH_HUNT;
            byte_pos_next = 5'd0;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (rx_byte == sync_word[7:0]) begin
            pending_next = rx_byte;
            phase_next   = PH_HIGH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      byte_pos <= 5'd0;
      pending  <= 8'd0;
      xor_acc  <= 16'd0;
    end else begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      pending  <= pending_next;
      xor_acc  <= xor_acc_next;
    end
  end

  // Store payload words; no reset, each is written before use
  always_ff @(posedge clk) begin
    if (word_we) begin
      frame_words[slot] <= word;
    end
  end

  assign rec.words = frame_words;
  assign rec.ok    = (word == xor_acc);

endmodule

// ----- rtl/core/ffr_queue.sv -----
`timescale 1ns / 1ps

module ffr_queue #(
  parameter int unsigned DEPTH = ffr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ffr_pkg::frame_rec_t din,
  input  logic                pop,
  output ffr_pkg::frame_rec_t dout,
  output logic                full,
  output logic                nonempty
);
  import ffr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_rec_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign dout     = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ----- rtl/core/ffr_back.sv -----
`timescale 1ns / 1ps

module ffr_back (
  input  logic                clk,
  input  logic                rst,
  input  ffr_pkg::cfg_t       cfg,
  input  logic                rec_avail,
  input  ffr_pkg::frame_rec_t rec,
  output logic                rec_take,
  input  logic                pop,
  output logic                empty,
  output ffr_pkg::frame_rec_t res,
  output logic [15:0]         res_turns_right,
  output logic [15:0]         res_turns_left
);
  import ffr_pkg::*;

  logic        out_valid;
  logic [15:0] prev_right, prev_left;
  logic [15:0] turns_right, turns_left;
  logic [15:0] turns_right_next, turns_left_next;

  assign empty    = !out_valid;
  assign rec_take = rec_avail && (!out_valid || pop);

  // Turn counters move only on a good frame
  always_comb begin
    turns_right_next = turns_right;
    turns_left_next  = turns_left;
    if (rec.ok) begin
      turns_right_next = turn_step(turns_right, prev_right, rec.words[W_CNT_R],
                                   cfg.wrap_low, cfg.wrap_high);
      turns_left_next  = turn_step(turns_left, prev_left, rec.words[W_CNT_L],
                                   cfg.wrap_low, cfg.wrap_high);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      prev_right  <= 16'd0;
      prev_left   <= 16'd0;
      turns_right <= 16'd0;
      turns_left  <= 16'd0;
    end else begin
      if (rec_take) begin
        out_valid   <= 1'b1;
        turns_right <= turns_right_next;
        turns_left  <= turns_left_next;
        if (rec.ok) begin
          prev_right <= rec.words[W_CNT_R];
          prev_left  <= rec.words[W_CNT_L];
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rec_take) begin
      res             <= rec;
      res_turns_right <= turns_right_next;
      res_turns_left  <= turns_left_next;
    end
  end

endmodule

// ----- rtl/core/feedback_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// Feedback frame receiver: one received byte per cycle while full is low.
// The checksum byte transfer loads the frame into the queue; the result register
// loads it from the queue once no result is held or the held one is popped.
// Throughput: one byte per cycle until the QDEPTH-frame queue fills and raises full.
// Reset (rst, synchronous): parser hunts, queue and result empty, counters zero.
module feedback_frame_receiver_unit #(
  parameter int unsigned QDEPTH = ffr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] command_one,
  output logic signed [15:0] command_two,
  output logic signed [15:0] speed_right,
  output logic signed [15:0] speed_left,
  output logic signed [15:0] count_right,
  output logic signed [15:0] count_left,
  output logic [15:0]        battery_word,
  output logic signed [15:0] temperature_word,
  output logic [15:0]        led_word,
  output logic               checksum_ok,
  output logic signed [15:0] turns_right,
  output logic signed [15:0] turns_left
);
  import ffr_pkg::*;

  cfg_t       cfg;
  frame_rec_t front_rec, queue_rec, res;
  logic       front_push, queue_nonempty, back_take;
  logic [15:0] res_tr, res_tl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word <= SYNC_WORD_RST;
      cfg.wrap_low  <= WRAP_LOW_RST;
      cfg.wrap_high <= WRAP_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_WORD: cfg.sync_word <= cfg_data;
        REG_WRAP_LOW:  cfg.wrap_low  <= cfg_data;
        REG_WRAP_HIGH: cfg.wrap_high <= cfg_data;
        default: ;
      endcase
    end
  end

  ffr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !full),
    .rx_byte   (rx_byte),
    .sync_word (cfg.sync_word),
    .rec_push  (front_push),
    .rec       (front_rec)
  );

  ffr_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .din      (front_rec),
    .pop      (back_take),
    .dout     (queue_rec),
    .full     (full),
    .nonempty (queue_nonempty)
  );

  ffr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .rec_avail       (queue_nonempty),
    .rec             (queue_rec),
    .rec_take        (back_take),
    .pop             (pop),
    .empty           (empty),
    .res             (res),
    .res_turns_right (res_tr),
    .res_turns_left  (res_tl)
  );

  // Drive result ports
  assign command_one      = $signed(res.words[W_CMD_ONE]);
  assign command_two      = $signed(res.words[W_CMD_TWO]);
  assign speed_right      = $signed(res.words[W_SPD_R]);
  assign speed_left       = $signed(res.words[W_SPD_L]);
  assign count_right      = $signed(res.words[W_CNT_R]);
  assign count_left       = $signed(res.words[W_CNT_L]);
  assign battery_word     = res.words[W_BATT];
  assign temperature_word = $signed(res.words[W_TEMP]);
  assign led_word         = res.words[W_LED];
  assign checksum_ok      = res.ok;
  assign turns_right      = $signed(res_tr);
  assign turns_left       = $signed(res_tl);

endmodule
